// ===== hdl/tmtt_pkg.sv =====
// shared constants, command codes and controller/datapath interface types
package tmtt_pkg;

  localparam int DEF_MAX_ENTRIES = 16;

  // field widths
  localparam int OPC_W   = 3;
  localparam int TICK_W  = 32;
  localparam int ETICK_W = 31;
  localparam int BPM_W   = 17;
  localparam int STAT_W  = 3;
  localparam int TIME_W  = 44;
  localparam int TPQ_W   = 16;
  localparam int ENTRY_W = ETICK_W + BPM_W;
  localparam int IN_W    = 88;
  localparam int OUT_W   = 64;

  // arithmetic constants
  localparam logic [BPM_W-1:0]  BPM_MIN_Q8   = 17'd5120;
  localparam logic [BPM_W-1:0]  BPM_MAX_Q8   = 17'd76800;
  localparam logic [BPM_W-1:0]  BPM_RESET_Q8 = 17'd30720;
  localparam logic [TPQ_W-1:0]  TPQ_RESET    = 16'd960;
  localparam logic [17:0]       US_FACTOR    = 18'd234375;
  localparam int                US_SHIFT     = 16;
  localparam int                PROD_W       = ETICK_W + 18;
  localparam int                DEN_W        = TPQ_W + BPM_W;
  localparam int                NUM_W        = PROD_W + US_SHIFT + 1;
  localparam int                DCNT_W       = $clog2(NUM_W + 1);
  localparam logic [TIME_W-1:0] TIME_MAX     = {TIME_W{1'b1}};

  // opcodes
  localparam logic [OPC_W-1:0] OPC_INSERT = 3'd0;
  localparam logic [OPC_W-1:0] OPC_REMOVE = 3'd1;
  localparam logic [OPC_W-1:0] OPC_SETBPM = 3'd2;
  localparam logic [OPC_W-1:0] OPC_MOVE   = 3'd3;
  localparam logic [OPC_W-1:0] OPC_QUERY  = 3'd4;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_BAD_TICK  = 3'd1;
  localparam logic [STAT_W-1:0] ST_BAD_BPM   = 3'd2;
  localparam logic [STAT_W-1:0] ST_DUPLICATE = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd4;
  localparam logic [STAT_W-1:0] ST_PROTECTED = 3'd5;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd6;
  localparam logic [STAT_W-1:0] ST_SAME_TICK = 3'd7;

  // datapath operations
  typedef enum logic [4:0] {
    OP_NOP,
    OP_LOAD,
    OP_RD,
    OP_RD1,
    OP_INC,
    OP_SCAN_INIT,
    OP_MARK,
    OP_SAVE,
    OP_I_POS,
    OP_SHUP_INIT,
    OP_WR_UP,
    OP_WR_NEW,
    OP_WR_DN,
    OP_DEC_CNT,
    OP_SET_BPM0,
    OP_WR_BPM,
    OP_Q_TEMPO,
    OP_SEG_MUL,
    OP_SEG_PREP,
    OP_DIV_STEP,
    OP_ACC,
    OP_FINISH
  } dp_op_t;

  localparam logic KEY_TICK  = 1'b0;
  localparam logic KEY_NAMED = 1'b1;
  localparam logic DT_ENTRY  = 1'b0;
  localparam logic DT_QUERY  = 1'b1;

  typedef struct packed {
    dp_op_t            op;
    logic              key_sel;
    logic              dt_sel;
    logic [STAT_W-1:0] status;
    logic              qres;
  } cmd_t;

  typedef struct packed {
    logic [OPC_W-1:0] opcode;
    logic             tneg;
    logic             nneg;
    logic             bpm_ok;
    logic             full;
    logic             tick_zero;
    logic             named_zero;
    logic             same;
    logic             i_end;
    logic             i_last;
    logic             i_lt_pos;
    logic             ge;
    logic             eq;
    logic             gt;
    logic             div_done;
    logic             out_free;
  } stat_t;

endpackage

// ===== hdl/tempo_map_tick_to_time.sv =====
// top level of the tempo map with tick to time conversion
// Keeps a tick-sorted tempo table (entry at tick 0 is fixed, 120 BPM at reset) and takes one
// operation per input transfer: insert, remove, set bpm, move or query, each answered by one
// result transfer with a status code. Items are handled one at a time; the result register lets
// the next item be taken while a result waits. Edits scan the table entry by entry and shift
// entries to open or close a gap. A query is accepted and dispatched, then walks the tempo
// segments; for each it does the table step, then the multiply, divider setup and the
// bit-serial divider giving one quotient bit a cycle over the 66-bit scaled dividend. The result
// then waits for the result register if needed. The table sits in a single-port-read memory
// whose registered read splits each scan step into a read state and a check state; no
// clearing pass is needed after reset.
module tempo_map_tick_to_time #(
  parameter int MAX_ENTRIES = tmtt_pkg::DEF_MAX_ENTRIES
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [tmtt_pkg::TPQ_W-1:0]  cfg_wr_data,  // ticks_per_quarter
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [tmtt_pkg::IN_W-1:0]   in_tdata,     // opcode, tick, named_tick, bpm_q8
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [tmtt_pkg::OUT_W-1:0]  out_tdata     // status, tempo_q8, time_us
);
  import tmtt_pkg::*;

  cmd_t  cmd;
  stat_t st;

  // sequencer
  tmtt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  // table and arithmetic
  tmtt_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tdata    (in_tdata),
    .cmd         (cmd),
    .st          (st),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .out_tdata   (out_tdata)
  );

  // an accepted transfer is captured in the same cycle
  a_load_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |-> (cmd.op == OP_LOAD))
    else $error("input transfer not captured");

  // never write a new entry into a full table
  a_no_insert_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_WR_NEW) |-> !st.full)
    else $error("insert into full table");

  // a result is only loaded when the output register can take it
  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_FINISH) |-> st.out_free)
    else $error("result overwrote pending output");

  // divider never steps past its last bit
  a_div_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_DIV_STEP) |-> !st.div_done)
    else $error("divider stepped after completion");

endmodule

// ===== hdl/tmtt_datapath.sv =====
// tempo table memory, index registers, segment multiplier/divider and result register
module tmtt_datapath #(
  parameter int MAX_ENTRIES = tmtt_pkg::DEF_MAX_ENTRIES
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [tmtt_pkg::TPQ_W-1:0] cfg_wr_data,
  input  logic [tmtt_pkg::IN_W-1:0]  in_tdata,
  input  tmtt_pkg::cmd_t            cmd,
  output tmtt_pkg::stat_t           st,
  input  logic                      out_tready,
  output logic                      out_tvalid,
  output logic [tmtt_pkg::OUT_W-1:0] out_tdata
);
  import tmtt_pkg::*;

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  logic [ENTRY_W-1:0] mem [MAX_ENTRIES];

  logic [TPQ_W-1:0]   tpq_r;
  logic [OPC_W-1:0]   opc_r;
  logic [TICK_W-1:0]  tick_r, named_r;
  logic [BPM_W-1:0]   bpm_r, bpm0_r, ins_bpm_r;
  logic [CW-1:0]      count_r, i_r, pos_r;
  logic [ENTRY_W-1:0] rdata_r;
  logic [BPM_W-1:0]   tempo_r, seg_bpm_r;
  logic [TIME_W-1:0]  time_r;
  logic [ETICK_W-1:0] seg_start_r;
  logic [PROD_W-1:0]  prod_r;
  logic [DEN_W-1:0]   den_r;
  logic [NUM_W-1:0]   num_r;
  logic [DEN_W-1:0]   rem_r;
  logic [TIME_W-1:0]  quo_r;
  logic               ovf_r;
  logic [DCNT_W-1:0]  div_cnt_r;
  logic               out_valid_r;
  logic [OUT_W-1:0]   out_data_r;

  logic [ETICK_W-1:0] rd_tick, key, dt;
  logic [BPM_W-1:0]   rd_bpm;
  logic [TPQ_W-1:0]   tpq_eff;
  logic [CW:0]        i_plus1;
  logic [AW-1:0]      addr_i, addr_i1, addr_pos;
  logic [DEN_W:0]     shifted, trial;
  logic               qbit;
  logic [TIME_W-1:0]  seg_us;
  logic [TIME_W:0]    sum;
  logic               out_free;

  assign rd_tick  = rdata_r[ENTRY_W-1:BPM_W];
  assign rd_bpm   = rdata_r[BPM_W-1:0];
  assign key      = (cmd.key_sel == KEY_NAMED) ? named_r[ETICK_W-1:0] : tick_r[ETICK_W-1:0];
  assign tpq_eff  = (tpq_r == '0) ? TPQ_W'(1) : tpq_r;
  assign i_plus1  = {1'b0, i_r} + (CW+1)'(1);
  assign addr_i   = i_r[AW-1:0];
  assign addr_i1  = i_plus1[AW-1:0];
  assign addr_pos = pos_r[AW-1:0];
  assign dt       = ((cmd.dt_sel == DT_QUERY) ? tick_r[ETICK_W-1:0] : rd_tick) - seg_start_r;

  // restoring divider step
  assign shifted = {rem_r, num_r[NUM_W-1]};
  assign trial   = shifted - {1'b0, den_r};
  assign qbit    = (shifted >= {1'b0, den_r});
  assign seg_us  = ovf_r ? TIME_MAX : quo_r;
  assign sum     = {1'b0, time_r} + {1'b0, seg_us};

  assign out_free = !out_valid_r || out_tready;

  // status to the controller
  always_comb begin
    st.opcode     = opc_r;
    st.tneg       = tick_r[TICK_W-1];
    st.nneg       = named_r[TICK_W-1];
    st.bpm_ok     = (bpm_r >= BPM_MIN_Q8) && (bpm_r <= BPM_MAX_Q8);
    st.full       = (count_r == CW'(MAX_ENTRIES));
    st.tick_zero  = (tick_r == '0);
    st.named_zero = (named_r == '0);
    st.same       = (tick_r == named_r);
    st.i_end      = (i_r == count_r);
    st.i_last     = (i_plus1 == {1'b0, count_r});
    st.i_lt_pos   = (i_r < pos_r);
    st.ge         = (rd_tick >= key);
    st.eq         = (rd_tick == key);
    st.gt         = (rd_tick > key);
    st.div_done   = (div_cnt_r == '0);
    st.out_free   = out_free;
  end

  // table memory write port
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_WR_UP:  mem[addr_i1] <= rdata_r;
      OP_WR_NEW: mem[addr_pos] <= {tick_r[ETICK_W-1:0], ins_bpm_r};
      OP_WR_DN:  mem[addr_i] <= rdata_r;
      OP_WR_BPM: mem[addr_i] <= {named_r[ETICK_W-1:0], bpm_r};
      default: ;
    endcase
  end

  // table memory read port
  always_ff @(posedge clk) begin
    if (cmd.op == OP_RD) begin
      rdata_r <= mem[addr_i];
    end else if (cmd.op == OP_RD1) begin
      rdata_r <= mem[addr_i1];
    end
  end

  // control state: counts, index, config, tick-0 tempo, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpq_r       <= TPQ_RESET;
      count_r     <= CW'(1);
      bpm0_r      <= BPM_RESET_Q8;
      i_r         <= CW'(1);
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        tpq_r <= cfg_wr_data;
      end
      case (cmd.op)
        OP_LOAD, OP_SCAN_INIT: i_r <= CW'(1);
        OP_INC, OP_WR_DN, OP_ACC: i_r <= i_plus1[CW-1:0];
        OP_I_POS:     i_r <= pos_r;
        OP_SHUP_INIT: i_r <= count_r - CW'(1);
        OP_WR_UP:     i_r <= i_r - CW'(1);
        OP_WR_NEW:    count_r <= count_r + CW'(1);
        OP_DEC_CNT:   count_r <= count_r - CW'(1);
        OP_SET_BPM0:  bpm0_r <= bpm_r;
        OP_SEG_PREP:  div_cnt_r <= DCNT_W'(NUM_W);
        OP_DIV_STEP:  div_cnt_r <= div_cnt_r - DCNT_W'(1);
        default: ;
      endcase
      if (cmd.op == OP_FINISH) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        opc_r       <= in_tdata[2:0];
        tick_r      <= in_tdata[34:3];
        named_r     <= in_tdata[66:35];
        bpm_r       <= in_tdata[83:67];
        ins_bpm_r   <= in_tdata[83:67];
        tempo_r     <= bpm0_r;
        seg_bpm_r   <= bpm0_r;
        seg_start_r <= '0;
        time_r      <= '0;
      end
      OP_MARK: pos_r <= i_r;
      OP_SAVE: begin
        pos_r     <= i_r;
        ins_bpm_r <= rd_bpm;
      end
      OP_Q_TEMPO: tempo_r <= rd_bpm;
      OP_SEG_MUL: begin
        prod_r <= dt * US_FACTOR;
        den_r  <= tpq_eff * seg_bpm_r;
        if (cmd.dt_sel == DT_ENTRY) begin
          seg_start_r <= rd_tick;
          seg_bpm_r   <= rd_bpm;
        end
      end
      OP_SEG_PREP: begin
        num_r <= {1'b0, prod_r, {US_SHIFT{1'b0}}} + NUM_W'(den_r[DEN_W-1:1]);
        rem_r <= '0;
        quo_r <= '0;
        ovf_r <= 1'b0;
      end
      OP_DIV_STEP: begin
        num_r <= {num_r[NUM_W-2:0], 1'b0};
        rem_r <= qbit ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
        quo_r <= {quo_r[TIME_W-2:0], qbit};
        ovf_r <= ovf_r | quo_r[TIME_W-1];
      end
      OP_ACC: time_r <= sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
      OP_FINISH: begin
        out_data_r <= {(cmd.qres ? time_r : TIME_W'(0)),
                       (cmd.qres ? tempo_r : BPM_W'(0)), cmd.status};
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== hdl/tmtt_ctrl.sv =====
// sequencer that steps the datapath through edits, table scans and queries
module tmtt_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  tmtt_pkg::stat_t st,
  output tmtt_pkg::cmd_t  cmd
);
  import tmtt_pkg::*;

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_DISP    = 5'd1;
  localparam logic [4:0] S_SC_RD   = 5'd2;
  localparam logic [4:0] S_SC_CK   = 5'd3;
  localparam logic [4:0] S_SC_END  = 5'd4;
  localparam logic [4:0] S_MV_SCAN = 5'd5;
  localparam logic [4:0] S_DN_CHK  = 5'd6;
  localparam logic [4:0] S_DN_WR   = 5'd7;
  localparam logic [4:0] S_DN_END  = 5'd8;
  localparam logic [4:0] S_UP_INIT = 5'd9;
  localparam logic [4:0] S_UP_CHK  = 5'd10;
  localparam logic [4:0] S_UP_WR   = 5'd11;
  localparam logic [4:0] S_Q_CHK   = 5'd12;
  localparam logic [4:0] S_Q_EV    = 5'd13;
  localparam logic [4:0] S_Q_SEG   = 5'd14;
  localparam logic [4:0] S_Q_FIN   = 5'd15;
  localparam logic [4:0] S_PREP    = 5'd16;
  localparam logic [4:0] S_DIV     = 5'd17;
  localparam logic [4:0] S_DONE    = 5'd18;

  localparam logic [2:0] P_INS = 3'd0;
  localparam logic [2:0] P_RM  = 3'd1;
  localparam logic [2:0] P_SET = 3'd2;
  localparam logic [2:0] P_MV1 = 3'd3;
  localparam logic [2:0] P_MV2 = 3'd4;
  localparam logic [2:0] P_MV3 = 3'd5;
  localparam logic [2:0] P_QRY = 3'd6;

  logic [4:0]        state_r, state_nxt;
  logic [2:0]        phase_r, phase_nxt;
  logic              found_r, found_nxt;
  logic [STAT_W-1:0] stat_r, stat_nxt;
  logic              qres_r, qres_nxt;
  logic              qlast_r, qlast_nxt;

  assign in_tready = (state_r == S_IDLE);

  // next state and command decode
  always_comb begin
    state_nxt   = state_r;
    phase_nxt   = phase_r;
    found_nxt   = found_r;
    stat_nxt    = stat_r;
    qres_nxt    = qres_r;
    qlast_nxt   = qlast_r;
    cmd.op      = OP_NOP;
    cmd.key_sel = (phase_r == P_RM || phase_r == P_SET || phase_r == P_MV1) ?
                  KEY_NAMED : KEY_TICK;
    cmd.dt_sel  = DT_ENTRY;
    cmd.status  = stat_r;
    cmd.qres    = qres_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        state_nxt = S_DONE;
        qres_nxt  = 1'b0;
        stat_nxt  = ST_OK;
        qlast_nxt = 1'b0;
        unique case (st.opcode)
          OPC_INSERT: begin
            if (st.tneg) stat_nxt = ST_BAD_TICK;
            else if (!st.bpm_ok) stat_nxt = ST_BAD_BPM;
            else if (st.tick_zero) stat_nxt = ST_DUPLICATE;
            else begin
              phase_nxt = P_INS;
              state_nxt = S_SC_RD;
            end
          end
          OPC_REMOVE: begin
            if (st.nneg) stat_nxt = ST_NOT_FOUND;
            else if (st.named_zero) stat_nxt = ST_PROTECTED;
            else begin
              phase_nxt = P_RM;
              state_nxt = S_SC_RD;
            end
          end
          OPC_SETBPM: begin
            if (!st.bpm_ok) stat_nxt = ST_BAD_BPM;
            else if (st.nneg) stat_nxt = ST_NOT_FOUND;
            else if (st.named_zero) cmd.op = OP_SET_BPM0;
            else begin
              phase_nxt = P_SET;
              state_nxt = S_SC_RD;
            end
          end
          OPC_MOVE: begin
            if (st.tneg) stat_nxt = ST_BAD_TICK;
            else if (st.nneg) stat_nxt = ST_NOT_FOUND;
            else if (st.named_zero) stat_nxt = ST_PROTECTED;
            else begin
              phase_nxt = P_MV1;
              state_nxt = S_SC_RD;
            end
          end
          OPC_QUERY: begin
            if (st.tneg) stat_nxt = ST_BAD_TICK;
            else begin
              phase_nxt = P_QRY;
              state_nxt = S_Q_CHK;
            end
          end
          default: ;
        endcase
      end
      // shared scan: first entry at or above the key
      S_SC_RD: begin
        if (st.i_end) begin
          found_nxt = 1'b0;
          state_nxt = S_SC_END;
        end else begin
          cmd.op    = OP_RD;
          state_nxt = S_SC_CK;
        end
      end
      S_SC_CK: begin
        if (st.ge) begin
          found_nxt = st.eq;
          state_nxt = S_SC_END;
        end else begin
          cmd.op    = OP_INC;
          state_nxt = S_SC_RD;
        end
      end
      S_SC_END: begin
        stat_nxt  = ST_OK;
        state_nxt = S_DONE;
        unique case (phase_r)
          P_INS: begin
            if (found_r) stat_nxt = ST_DUPLICATE;
            else if (st.full) stat_nxt = ST_FULL;
            else begin
              cmd.op    = OP_MARK;
              state_nxt = S_UP_INIT;
            end
          end
          P_RM: begin
            if (!found_r) stat_nxt = ST_NOT_FOUND;
            else state_nxt = S_DN_CHK;
          end
          P_SET: begin
            if (!found_r) stat_nxt = ST_NOT_FOUND;
            else cmd.op = OP_WR_BPM;
          end
          P_MV1: begin
            if (!found_r) stat_nxt = ST_NOT_FOUND;
            else if (st.same) stat_nxt = ST_SAME_TICK;
            else begin
              cmd.op    = OP_SAVE;
              state_nxt = S_MV_SCAN;
            end
          end
          P_MV2: begin
            if (found_r) stat_nxt = ST_DUPLICATE;
            else begin
              cmd.op    = OP_I_POS;
              phase_nxt = P_MV3;
              state_nxt = S_DN_CHK;
            end
          end
          P_MV3: begin
            cmd.op    = OP_MARK;
            state_nxt = S_UP_INIT;
          end
          default: ;
        endcase
      end
      S_MV_SCAN: begin
        if (st.tick_zero) begin
          stat_nxt  = ST_DUPLICATE;
          state_nxt = S_DONE;
        end else begin
          cmd.op    = OP_SCAN_INIT;
          phase_nxt = P_MV2;
          state_nxt = S_SC_RD;
        end
      end
      // close the gap left by a removed entry
      S_DN_CHK: begin
        if (st.i_last) begin
          cmd.op    = OP_DEC_CNT;
          state_nxt = S_DN_END;
        end else begin
          cmd.op    = OP_RD1;
          state_nxt = S_DN_WR;
        end
      end
      S_DN_WR: begin
        cmd.op    = OP_WR_DN;
        state_nxt = S_DN_CHK;
      end
      S_DN_END: begin
        if (phase_r == P_MV3) begin
          cmd.op    = OP_SCAN_INIT;
          state_nxt = S_SC_RD;
        end else begin
          stat_nxt  = ST_OK;
          state_nxt = S_DONE;
        end
      end
      // open a gap at the insert position
      S_UP_INIT: begin
        cmd.op    = OP_SHUP_INIT;
        state_nxt = S_UP_CHK;
      end
      S_UP_CHK: begin
        if (st.i_lt_pos) begin
          cmd.op    = OP_WR_NEW;
          stat_nxt  = ST_OK;
          state_nxt = S_DONE;
        end else begin
          cmd.op    = OP_RD;
          state_nxt = S_UP_WR;
        end
      end
      S_UP_WR: begin
        cmd.op    = OP_WR_UP;
        state_nxt = S_UP_CHK;
      end
      // query walk over tempo changes
      S_Q_CHK: begin
        if (st.i_end) begin
          state_nxt = S_Q_FIN;
        end else begin
          cmd.op    = OP_RD;
          state_nxt = S_Q_EV;
        end
      end
      S_Q_EV: begin
        if (st.gt) begin
          state_nxt = S_Q_FIN;
        end else begin
          cmd.op    = OP_Q_TEMPO;
          state_nxt = st.eq ? S_Q_FIN : S_Q_SEG;
        end
      end
      S_Q_SEG: begin
        cmd.op    = OP_SEG_MUL;
        cmd.dt_sel = DT_ENTRY;
        state_nxt = S_PREP;
      end
      S_Q_FIN: begin
        if (st.tick_zero) begin
          stat_nxt  = ST_OK;
          qres_nxt  = 1'b1;
          state_nxt = S_DONE;
        end else begin
          cmd.op     = OP_SEG_MUL;
          cmd.dt_sel = DT_QUERY;
          qlast_nxt  = 1'b1;
          state_nxt  = S_PREP;
        end
      end
      S_PREP: begin
        cmd.op    = OP_SEG_PREP;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (st.div_done) begin
          cmd.op = OP_ACC;
          if (qlast_r) begin
            stat_nxt  = ST_OK;
            qres_nxt  = 1'b1;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_Q_CHK;
          end
        end else begin
          cmd.op = OP_DIV_STEP;
        end
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.op    = OP_FINISH;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // controller registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= P_INS;
      found_r <= 1'b0;
      stat_r  <= ST_OK;
      qres_r  <= 1'b0;
      qlast_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      found_r <= found_nxt;
      stat_r  <= stat_nxt;
      qres_r  <= qres_nxt;
      qlast_r <= qlast_nxt;
    end
  end

endmodule
